// File: design/u8san_pkg.sv
package u8san_pkg;

    localparam logic [7:0] ASCII_MAX   = 8'h7F;
    localparam logic [7:0] BAD_LEAD_HI = 8'hC1;
    localparam logic [7:0] LEAD2_MAX   = 8'hDF;
    localparam logic [7:0] LEAD3_MAX   = 8'hEF;
    localparam logic [7:0] LEAD4_END   = 8'hF5;
    localparam logic [7:0] LEAD3_LOW   = 8'hE0;
    localparam logic [7:0] LEAD4_LOW   = 8'hF0;
    localparam logic [7:0] CONT_MIN    = 8'h80;
    localparam logic [7:0] CONT_MAX    = 8'hBF;
    localparam logic [7:0] E0_CONT_MIN = 8'hA0;
    localparam logic [7:0] F0_CONT_MIN = 8'h90;

    localparam logic CFG_REPLACE_ENABLE = 1'b0;
    localparam logic CFG_REPLACE_BYTE   = 1'b1;

    typedef logic [3:0][7:0] byte_vec_t;

    typedef enum logic [1:0] {
        JK_WAIT,
        JK_BAD,
        JK_OK
    } judge_kind_t;

    typedef struct packed {
        judge_kind_t kind;
        logic [2:0]  len;
    } judge_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       has_byte;
        logic       was_replaced;
        logic       last_out;
    } res_t;

    typedef enum logic [1:0] {
        F_IDLE,
        F_WORK,
        F_DONE
    } front_state_t;

    function automatic judge_t judge(input byte_vec_t q, input logic [2:0] n, input logic fin);
        logic [2:0] need;
        logic [7:0] lo1;
        logic [7:0] lo;
        logic [7:0] d;
        logic       done;
        judge_t     r;
        r.kind = JK_OK;
        r.len  = 3'd1;
        need   = 3'd1;
        lo1    = CONT_MIN;
        done   = 1'b0;
        if (q[0] <= ASCII_MAX) begin
            need = 3'd1;
        end else if (q[0] <= BAD_LEAD_HI) begin
            r.kind = JK_BAD;
            done   = 1'b1;
        end else if (q[0] <= LEAD2_MAX) begin
            need = 3'd2;
        end else if (q[0] <= LEAD3_MAX) begin
            need = 3'd3;
            if (q[0] == LEAD3_LOW) begin
                lo1 = E0_CONT_MIN;
            end
        end else if (q[0] < LEAD4_END) begin
            need = 3'd4;
            if (q[0] == LEAD4_LOW) begin
                lo1 = F0_CONT_MIN;
            end
        end else begin
            r.kind = JK_BAD;
            done   = 1'b1;
        end
        for (int i = 1; i < 4; i++) begin
            if (!done && (3'(i) < need)) begin
                if (3'(i) >= n) begin
                    r.kind = fin ? JK_BAD : JK_WAIT;
                    done   = 1'b1;
                end else begin
                    d  = q[2'(i)];
                    lo = (i == 1) ? lo1 : CONT_MIN;
                    if ((d < lo) || (d > CONT_MAX)) begin
                        r.kind = JK_BAD;
                        done   = 1'b1;
                    end
                end
            end
        end
        if (!done) begin
            r.len = need;
        end
        return r;
    endfunction

endpackage

// File: design/u8san_front.sv
module u8san_front (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  logic [7:0]      s_tdata,
    input  logic            s_tlast,
    input  logic            cfg_wr_en,
    input  logic            cfg_index,
    input  logic [7:0]      cfg_wdata,
    output logic            push,
    output u8san_pkg::res_t push_data,
    input  logic            full
);

    u8san_pkg::front_state_t state_reg, state_next;
    u8san_pkg::byte_vec_t    q_reg, q_next;
    logic [2:0]              n_reg, n_next;
    logic                    fin_reg, fin_next;
    logic [1:0]              emit_reg, emit_next;
    logic                    hold_valid_reg, hold_valid_next;
    u8san_pkg::res_t         hold_reg, hold_next;
    logic                    rep_en_reg;
    logic [7:0]              rep_byte_reg;

    u8san_pkg::judge_t jr;
    u8san_pkg::res_t   prod_entry;
    logic              produce;
    logic              shift;
    logic              to_done;
    logic              stall;
    logic              accept;

    assign jr     = u8san_pkg::judge(q_reg, n_reg, fin_reg);
    assign accept = s_tvalid && s_tready;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            u8san_pkg::F_IDLE: begin
                if (accept) begin
                    state_next = u8san_pkg::F_WORK;
                end
            end
            u8san_pkg::F_WORK: begin
                if (to_done) begin
                    state_next = u8san_pkg::F_DONE;
                end
            end
            u8san_pkg::F_DONE: begin
                if (!stall) begin
                    state_next = u8san_pkg::F_IDLE;
                end
            end
            default: begin
                state_next = u8san_pkg::F_IDLE;
            end
        endcase
    end

    always_comb begin
        s_tready        = 1'b0;
        produce         = 1'b0;
        shift           = 1'b0;
        to_done         = 1'b0;
        stall           = 1'b0;
        push            = 1'b0;
        push_data       = hold_reg;
        prod_entry      = '{out_byte: q_reg[0], has_byte: 1'b1, was_replaced: 1'b0,
                            last_out: 1'b0};
        q_next          = q_reg;
        n_next          = n_reg;
        fin_next        = fin_reg;
        emit_next       = emit_reg;
        hold_next       = hold_reg;
        hold_valid_next = hold_valid_reg;
        case (state_reg)
            u8san_pkg::F_IDLE: begin
                s_tready = 1'b1;
                if (accept) begin
                    q_next[n_reg[1:0]] = s_tdata;
                    n_next             = n_reg + 3'd1;
                    fin_next           = s_tlast;
                    emit_next          = 2'd0;
                end
            end
            u8san_pkg::F_WORK: begin
                if (emit_reg != 2'd0) begin
                    produce   = 1'b1;
                    shift     = 1'b1;
                    emit_next = emit_reg - 2'd1;
                end else if (n_reg == 3'd0) begin
                    to_done = 1'b1;
                end else begin
                    case (jr.kind)
                        u8san_pkg::JK_WAIT: begin
                            to_done = 1'b1;
                        end
                        u8san_pkg::JK_BAD: begin
                            produce    = rep_en_reg;
                            prod_entry = '{out_byte: rep_byte_reg, has_byte: 1'b1,
                                           was_replaced: 1'b1, last_out: 1'b0};
                            shift      = 1'b1;
                        end
                        u8san_pkg::JK_OK: begin
                            produce   = 1'b1;
                            shift     = 1'b1;
                            emit_next = 2'(jr.len - 3'd1);
                        end
                        default: begin
                            to_done = 1'b1;
                        end
                    endcase
                end
                stall = produce && hold_valid_reg && full;
                push  = produce && hold_valid_reg && !full;
                if (stall) begin
                    emit_next = emit_reg;
                end else begin
                    if (shift) begin
                        q_next[0] = q_reg[1];
                        q_next[1] = q_reg[2];
                        q_next[2] = q_reg[3];
                        n_next    = n_reg - 3'd1;
                    end
                    if (produce) begin
                        hold_next       = prod_entry;
                        hold_valid_next = 1'b1;
                    end
                end
            end
            u8san_pkg::F_DONE: begin
                if (fin_reg) begin
                    push = !full;
                    stall = full;
                    if (hold_valid_reg) begin
                        push_data          = hold_reg;
                        push_data.last_out = 1'b1;
                    end else begin
                        push_data = '{out_byte: 8'h00, has_byte: 1'b0, was_replaced: 1'b0,
                                      last_out: 1'b1};
                    end
                end else begin
                    push  = hold_valid_reg && !full;
                    stall = hold_valid_reg && full;
                end
                if (!stall) begin
                    hold_valid_next = 1'b0;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= u8san_pkg::F_IDLE;
            n_reg          <= 3'd0;
            fin_reg        <= 1'b0;
            emit_reg       <= 2'd0;
            hold_valid_reg <= 1'b0;
            rep_en_reg     <= 1'b0;
            rep_byte_reg   <= 8'h00;
        end else begin
            state_reg      <= state_next;
            n_reg          <= n_next;
            fin_reg        <= fin_next;
            emit_reg       <= emit_next;
            hold_valid_reg <= hold_valid_next;
            if (cfg_wr_en) begin
                case (cfg_index)
                    u8san_pkg::CFG_REPLACE_ENABLE: rep_en_reg   <= cfg_wdata[0];
                    u8san_pkg::CFG_REPLACE_BYTE:   rep_byte_reg <= cfg_wdata;
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        q_reg    <= q_next;
        hold_reg <= hold_next;
    end

endmodule

// File: design/u8san_queue.sv
module u8san_queue #(
    parameter int DEPTH = 4
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  u8san_pkg::res_t push_data,
    output logic            full,
    input  logic            pop,
    output u8san_pkg::res_t pop_data,
    output logic            empty
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    u8san_pkg::res_t mem [DEPTH];
    logic [AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg, count_next;

    assign full     = (count_reg == CW'(DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// File: design/u8san_back.sv
module u8san_back (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            empty,
    input  u8san_pkg::res_t pop_data,
    output logic            pop,
    output logic            m_tvalid,
    input  logic            m_tready,
    output logic [7:0]      m_tdata,
    output logic [1:0]      m_tuser,
    output logic            m_tlast
);

    logic            out_valid_reg, out_valid_next;
    u8san_pkg::res_t out_reg;

    assign pop            = !empty && (!out_valid_reg || m_tready);
    assign out_valid_next = pop || (out_valid_reg && !m_tready);

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg.out_byte;
    assign m_tuser  = {out_reg.was_replaced, out_reg.has_byte};
    assign m_tlast  = out_reg.last_out;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            out_reg <= pop_data;
        end
    end

endmodule

// File: design/utf8_stream_sanitizer_top.sv
// channel   dir  handshake            payload
// s_        in   s_tvalid/s_tready    s_tdata[7:0] in_byte, s_tlast end_of_buffer
// m_        out  m_tvalid/m_tready    m_tdata[7:0] out_byte, m_tuser has_byte/was_replaced,
//                                     m_tlast last_out
// cfg_      in   cfg_wr_en            cfg_index selects register, cfg_wdata[7:0] value
//
// Each request passes through the front sequencer's F_IDLE, F_WORK and F_DONE states; in F_WORK
// the sequencer judges or emits one byte per cycle unless a full queue stalls it.
// The back stage delivers one result per cycle from the result queue while m_tready is high.
// Reset clears the held character, the queue pointers and both registers.
// A full queue holds the front; m_tready low holds the back and fills the queue.
module utf8_stream_sanitizer_top #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // in_byte
    input  logic       s_tlast,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // out_byte
    output logic [1:0] m_tuser,   // [1] was_replaced, [0] has_byte
    output logic       m_tlast,
    input  logic       cfg_wr_en,
    input  logic       cfg_index,
    input  logic [7:0] cfg_wdata
);

    logic            push;
    u8san_pkg::res_t push_data;
    logic            full;
    logic            pop;
    u8san_pkg::res_t pop_data;
    logic            empty;

    u8san_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .push      (push),
        .push_data (push_data),
        .full      (full)
    );

    u8san_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .full      (full),
        .pop       (pop),
        .pop_data  (pop_data),
        .empty     (empty)
    );

    u8san_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .empty    (empty),
        .pop_data (pop_data),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

// File: sim/testbench.sv
`timescale 1ns / 1ps

module testbench;

    localparam int SETTLE_CYCLES = 16;
    localparam int STALL_LIMIT   = 1000;

    logic       aclk;
    logic       aresetn;
    logic       s_tvalid;
    logic       s_tready;
    logic [7:0] s_tdata;   // in_byte
    logic       s_tlast;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;   // out_byte
    logic [1:0] m_tuser;   // [1] was_replaced, [0] has_byte
    logic       m_tlast;
    logic       cfg_wr_en;
    logic       cfg_index;
    logic [7:0] cfg_wdata;

    // sanitizer shadow: held character bytes and register copies
    logic [7:0] held [3];
    int         held_n = 0;
    logic       rep_on = 1'b0;
    logic [7:0] rep_val = 8'h00;

    u8san_pkg::res_t expected_out [$];
    u8san_pkg::res_t oldest;
    logic [7:0]      buffer_bytes [$];

    logic       no_gaps = 1'b0;
    int         stall_left = 0;
    int         idle_cycles = 0;
    int         mismatches = 0;
    int         requests = 0;
    int         buffers = 0;
    int         results_seen = 0;
    int         replacements = 0;
    int         end_markers = 0;

    utf8_stream_sanitizer_top u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // -1: lead byte is bad, 0: need more bytes, k: complete character of k bytes
    function automatic int char_len(input logic [7:0] w [4], input int n, input logic fin);
        int         need;
        logic [7:0] lo;
        lo = u8san_pkg::CONT_MIN;
        if (w[0] <= u8san_pkg::ASCII_MAX) return 1;
        if (w[0] <= u8san_pkg::BAD_LEAD_HI || w[0] >= u8san_pkg::LEAD4_END) return -1;
        if (w[0] <= u8san_pkg::LEAD2_MAX) begin
            need = 2;
        end else if (w[0] <= u8san_pkg::LEAD3_MAX) begin
            need = 3;
            if (w[0] == u8san_pkg::LEAD3_LOW) lo = u8san_pkg::E0_CONT_MIN;
        end else begin
            need = 4;
            if (w[0] == u8san_pkg::LEAD4_LOW) lo = u8san_pkg::F0_CONT_MIN;
        end
        for (int i = 1; i < need; i++) begin
            if (i >= n) return fin ? -1 : 0;
            if (w[i] < lo || w[i] > u8san_pkg::CONT_MAX) return -1;
            lo = u8san_pkg::CONT_MIN;
        end
        return need;
    endfunction

    task automatic predict_request(input logic [7:0] b, input logic eob);
        logic [7:0]      w [4];
        u8san_pkg::res_t outs [5];
        int              n;
        int              r;
        int              cnt;
        logic            undecided;
        n = 0;
        cnt = 0;
        undecided = 1'b0;
        for (int i = 0; i < held_n; i++) begin
            w[n] = held[i];
            n++;
        end
        w[n] = b;
        n++;
        while (n > 0 && !undecided) begin
            r = char_len(w, n, eob);
            if (r == 0) begin
                undecided = 1'b1;
            end else begin
                if (r < 0) begin
                    if (rep_on) begin
                        outs[cnt] = '{out_byte: rep_val, has_byte: 1'b1, was_replaced: 1'b1,
                                      last_out: 1'b0};
                        cnt++;
                        replacements++;
                    end
                    r = 1;
                end else begin
                    for (int i = 0; i < r; i++) begin
                        outs[cnt] = '{out_byte: w[i], has_byte: 1'b1, was_replaced: 1'b0,
                                      last_out: 1'b0};
                        cnt++;
                    end
                end
                for (int i = r; i < n; i++) w[i - r] = w[i];
                n -= r;
            end
        end
        for (int i = 0; i < n; i++) held[i] = w[i];
        held_n = n;
        if (eob) begin
            if (cnt == 0) begin
                outs[0] = '{out_byte: 8'h00, has_byte: 1'b0, was_replaced: 1'b0, last_out: 1'b0};
                cnt = 1;
                end_markers++;
            end
            outs[cnt - 1].last_out = 1'b1;
        end
        for (int i = 0; i < cnt; i++) expected_out.insert(expected_out.size(), outs[i]);
    endtask

    task automatic send_byte(input logic [7:0] b, input logic eob);
        int gap;
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= eob;
        do @(posedge aclk); while (!s_tready);
        requests++;
        predict_request(b, eob);
        gap = no_gaps ? 0 : pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic hold_for_results();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (expected_out.size() != 0);
    endtask

    task automatic settle();
        hold_for_results();
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic set_config(input logic en, input logic [7:0] val);
        settle();
        cfg_wr_en <= 1'b1;
        cfg_index <= u8san_pkg::CFG_REPLACE_ENABLE;
        cfg_wdata <= {7'($urandom), en};
        @(posedge aclk);
        cfg_index <= u8san_pkg::CFG_REPLACE_BYTE;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        rep_on  = en;
        rep_val = val;
    endtask

    task automatic send_buffer();
        buffers++;
        no_gaps = ($urandom_range(0, 4) == 0);
        for (int i = 0; i < buffer_bytes.size(); i++) begin
            send_byte(buffer_bytes[i], i == buffer_bytes.size() - 1);
            if ($urandom_range(0, 39) == 0) hold_for_results();
        end
        no_gaps = 1'b0;
    endtask

    task automatic add_byte(input logic [7:0] b);
        buffer_bytes.insert(buffer_bytes.size(), b);
    endtask

    function automatic logic [7:0] cont_byte();
        return 8'($urandom_range(8'h80, 8'hBF));
    endfunction

    task automatic add_char();
        int         kind;
        int         need;
        logic [7:0] lead;
        kind = $urandom_range(0, 99);
        if (kind < 25) begin
            add_byte(8'($urandom_range(0, 8'h7F)));
        end else if (kind < 40) begin
            add_byte(8'($urandom_range(8'hC2, 8'hDF)));
            add_byte(cont_byte());
        end else if (kind < 55) begin
            lead = 8'($urandom_range(8'hE0, 8'hEF));
            add_byte(lead);
            add_byte(lead == u8san_pkg::LEAD3_LOW ? 8'($urandom_range(8'hA0, 8'hBF))
                                                  : cont_byte());
            add_byte(cont_byte());
        end else if (kind < 68) begin
            lead = 8'($urandom_range(8'hF0, 8'hF4));
            add_byte(lead);
            add_byte(lead == u8san_pkg::LEAD4_LOW ? 8'($urandom_range(8'h90, 8'hBF))
                                                  : cont_byte());
            add_byte(cont_byte());
            add_byte(cont_byte());
        end else if (kind < 78) begin
            // truncated character
            need = $urandom_range(2, 4);
            lead = (need == 2) ? 8'($urandom_range(8'hC2, 8'hDF)) :
                   (need == 3) ? 8'($urandom_range(8'hE1, 8'hEF)) :
                                 8'($urandom_range(8'hF1, 8'hF4));
            add_byte(lead);
            repeat ($urandom_range(0, need - 2)) add_byte(cont_byte());
        end else if (kind < 88) begin
            // lead followed by a byte that breaks it
            case ($urandom_range(0, 2))
                0: begin
                    add_byte(u8san_pkg::LEAD3_LOW);
                    add_byte(8'($urandom_range(8'h80, 8'h9F)));
                end
                1: begin
                    add_byte(u8san_pkg::LEAD4_LOW);
                    add_byte(8'($urandom_range(8'h80, 8'h8F)));
                end
                default: begin
                    add_byte(8'($urandom_range(8'hC2, 8'hF4)));
                    add_byte($urandom_range(0, 1) ? 8'($urandom_range(0, 8'h7F))
                                                  : 8'($urandom_range(8'hC0, 8'hFF)));
                end
            endcase
        end else begin
            add_byte(8'($urandom));
        end
    endtask

    task automatic test_single_bytes();
        buffer_bytes = '{8'h00, 8'h7F, 8'h80, 8'hC1, 8'hF5, 8'hFF};
        send_buffer();
    endtask

    task automatic test_multibyte();
        buffer_bytes = '{8'hC2, 8'h80, 8'hDF, 8'hBF, 8'hE0, 8'hA0, 8'hBF,
                         8'hF4, 8'h8F, 8'hBF, 8'hBF};
        send_buffer();
    endtask

    task automatic test_bad_sequences();
        set_config(1'b1, 8'hFF);
        buffer_bytes = '{8'hE0, 8'h9F, 8'hF0, 8'h8F, 8'hE1, 8'h80, 8'h41, 8'hC3};
        send_buffer();
    endtask

    task automatic test_random_buffers();
        int first;
        for (int round = 0; round < 4; round++) begin
            case (round)
                0:       set_config(1'b0, 8'($urandom));
                1:       set_config(1'b1, 8'h00);
                2:       set_config(1'b1, 8'hFF);
                default: set_config(1'b1, 8'($urandom));
            endcase
            first = requests;
            while (requests - first < 20) begin
                buffer_bytes.delete();
                repeat ($urandom_range(1, 6)) add_char();
                send_buffer();
            end
        end
    endtask

    always @(posedge aclk) begin
        if (stall_left == 0 && !no_gaps) stall_left = pick_gap();
        if (stall_left > 0) begin
            m_tready <= 1'b0;
            stall_left--;
        end else begin
            m_tready <= 1'b1;
        end
    end

    function automatic void check_field(input string what, input logic [7:0] want,
                                        input logic [7:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %h, got %h", $time, what, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            results_seen++;
            if (expected_out.size() == 0) begin
                $display("%0t: result with nothing expected, expected none, got %h user %b last %b",
                         $time, m_tdata, m_tuser, m_tlast);
                mismatches++;
            end else begin
                oldest = expected_out.pop_front();
                check_field("out_byte", oldest.out_byte, m_tdata);
                check_field("has_byte", 8'(oldest.has_byte), 8'(m_tuser[0]));
                check_field("was_replaced", 8'(oldest.was_replaced), 8'(m_tuser[1]));
                check_field("last_out", 8'(oldest.last_out), 8'(m_tlast));
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("%0t: no progress for %0d cycles, %0d results outstanding",
                     $time, STALL_LIMIT, expected_out.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= 8'h00;
        s_tlast   <= 1'b0;
        cfg_wr_en <= 1'b0;
        cfg_index <= u8san_pkg::CFG_REPLACE_ENABLE;
        cfg_wdata <= 8'h00;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        test_single_bytes();
        test_multibyte();
        test_bad_sequences();
        test_random_buffers();
        settle();
        $display("covered %0d input bytes in %0d buffers over drop and replace settings",
                 requests, buffers);
        $display("checked %0d results: %0d replacements, %0d empty end markers",
                 results_seen, replacements, end_markers);
        if (mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// File: utf8_stream_sanitizer_top.f
design/u8san_pkg.sv
design/u8san_front.sv
design/u8san_queue.sv
design/u8san_back.sv
design/utf8_stream_sanitizer_top.sv
sim/testbench.sv
